@@ design/rrts_pkg.sv @@
`timescale 1ns / 1ps
// Package for the round-robin task scheduler: command, state and status codes.
// No dependencies.
package rrts_pkg;
   localparam int SlotsDefault = 16;
   localparam logic [2:0] CMD_TICK = 3'd0;
   localparam logic [2:0] CMD_SLEEP = 3'd1;
   localparam logic [2:0] CMD_BLOCK = 3'd2;
   localparam logic [2:0] CMD_WAKE = 3'd3;
   localparam logic [2:0] CMD_YIELD = 3'd4;
   localparam logic [2:0] CMD_ADMIT = 3'd5;
   localparam logic [2:0] CMD_RETIRE = 3'd6;
   localparam logic [2:0] CMD_UNUSED = 3'd7;
   localparam logic [1:0] ST_UNUSED = 2'd0;
   localparam logic [1:0] ST_RUN = 2'd1;
   localparam logic [1:0] ST_WAIT = 2'd2;
   localparam logic [1:0] WR_NONE = 2'd0;
   localparam logic [1:0] WR_SLEEP = 2'd1;
   localparam logic [1:0] WR_INPUT = 2'd2;
   localparam logic [1:0] STS_OK = 2'd0;
   localparam logic [1:0] STS_REFUSED = 2'd1;
   localparam logic [1:0] STS_BAD_SLOT = 2'd2;
   localparam logic [15:0] SLICE_RESET = 16'd10;
   localparam logic [15:0] TICK_MS_RESET = 16'd1;
   localparam int CSR_SLICE = 0;
   localparam int CSR_TICK_MS = 1;

   typedef struct packed {
      logic [2:0] command;
      logic [3:0] slot;
      logic [31:0] sleep_ms;
   } req_type;

   typedef struct packed {
      logic [3:0] running_slot;
      logic switched;
      logic none_runnable;
      logic resched_pending;
      logic [4:0] woken_count;
      logic [1:0] status;
   } rsp_type;
endpackage

@@ design/rrts_if.sv @@
`timescale 1ns / 1ps
// Valid/ready channel interface carrying one payload per transaction.
// Depends on nothing but the payload type handed in.
interface rrts_if #(parameter type payload_type = logic) (input logic clock);
   logic valid;
   logic ready;
   payload_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

@@ design/round_robin_task_scheduler.sv @@
`timescale 1ns / 1ps
// Round-robin task scheduler over a table of task slots; slot 0 is idle.
// Uses rrts_pkg and the rrts_if channel interface.
//
// Usage: commands arrive on the req channel, one result per command leaves
// on the rsp channel. Configuration registers slice_ticks (0x0) and tick_ms
// (0x4) are written through the csr APB port, by the user only while the
// block is idle; the block itself does not enforce this. One command is
// worked at a time; req_ready is low while it runs. Tick and wake walk the
// slots one per cycle through a shared compare unit; yield walks them until
// it finds a runnable task. Tick then charges the running task; every walk
// ends in the done state, which raises rsp_valid. Sleep first divides the
// millisecond count by tick_ms with a restoring divider, one quotient bit a
// cycle, then yields. Admit, retire and refused commands go straight to the
// done state. The result sits in an output register until taken; while the
// receiver stalls, no new command is accepted.
// Synchronous reset clears all slot state, tick counter, current slot and
// reschedule flag, and loads the register defaults (slice 10, 1 ms per tick).
module round_robin_task_scheduler #(
   parameter int SLOTS = rrts_pkg::SlotsDefault
) (
   input logic clock,
   input logic reset,
   rrts_if.sink req,
   rrts_if.source rsp,
   input logic csr_psel,
   input logic csr_penable,
   input logic csr_pwrite,
   input logic [2:0] csr_paddr,
   input logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic csr_pready
);
   import rrts_pkg::*;

   localparam int SW = $clog2(SLOTS);

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_DIV = 3'd1;
   localparam logic [2:0] S_SCAN = 3'd2;
   localparam logic [2:0] S_YSCAN = 3'd3;
   localparam logic [2:0] S_CHARGE = 3'd4;
   localparam logic [2:0] S_DONE = 3'd5;

   logic [2:0] state_ff, state_in;
   logic [15:0] slice_ff, slice_in, tms_ff, tms_in;
   logic [1:0] sst_ff [SLOTS], sst_in [SLOTS];
   logic [1:0] wr_ff [SLOTS], wr_in [SLOTS];
   logic [63:0] dl_ff [SLOTS], dl_in [SLOTS];
   logic [15:0] sl_ff [SLOTS], sl_in [SLOTS];
   logic [31:0] rt_ff [SLOTS], rt_in [SLOTS];
   logic [31:0] sc_ff [SLOTS], sc_in [SLOTS];
   logic [63:0] tc_ff, tc_in;
   logic [SW-1:0] cur_ff, cur_in;
   logic rf_ff, rf_in;
   req_type cmd_ff, cmd_in;
   rsp_type out_ff, out_in;
   logic ov_ff, ov_in;
   logic [SW:0] idx_ff, idx_in;
   logic [5:0] dcnt_ff, dcnt_in;
   logic [31:0] quo_ff, quo_in;
   logic [16:0] rem_ff, rem_in;
   logic [SW:0] ysum;
   logic [SW-1:0] ys;
   logic [SW-1:0] tslot;
   logic [16:0] rsh;
   logic [15:0] divisor;
   logic csr_wr;

   assign csr_pready = 1'b1;
   assign csr_wr = csr_psel && csr_penable && csr_pwrite;
   assign csr_prdata = (csr_paddr[2] == 1'b1) ? {16'd0, tms_ff} : {16'd0, slice_ff};
   assign divisor = (tms_ff == 16'd0) ? 16'd1 : tms_ff;
   assign req.ready = (state_ff == S_IDLE) && !ov_ff;
   assign rsp.valid = ov_ff;
   assign rsp.payload = out_ff;
   assign ysum = {1'b0, cur_ff} + idx_ff;
   assign ys = (ysum >= (SW+1)'(SLOTS)) ? SW'(ysum - (SW+1)'(SLOTS)) : ysum[SW-1:0];
   assign tslot = SW'(req.payload.slot);
   assign rsh = {rem_ff[15:0], cmd_ff.sleep_ms[5'd31 - dcnt_ff[4:0]]};

   always_comb begin
      state_in = state_ff;
      slice_in = slice_ff;
      tms_in = tms_ff;
      sst_in = sst_ff;
      wr_in = wr_ff;
      dl_in = dl_ff;
      sl_in = sl_ff;
      rt_in = rt_ff;
      sc_in = sc_ff;
      tc_in = tc_ff;
      cur_in = cur_ff;
      rf_in = rf_ff;
      cmd_in = cmd_ff;
      out_in = out_ff;
      ov_in = ov_ff;
      idx_in = idx_ff;
      dcnt_in = dcnt_ff;
      quo_in = quo_ff;
      rem_in = rem_ff;
      if (csr_wr) begin
         if (csr_paddr[2] == 1'b0) begin
            slice_in = csr_pwdata[15:0];
         end else begin
            tms_in = csr_pwdata[15:0];
         end
      end
      if (rsp.valid && rsp.ready) begin
         ov_in = 1'b0;
      end
      case (state_ff)
         S_IDLE: begin
            if (req.valid && req.ready) begin
               cmd_in = req.payload;
               out_in = '0;
               idx_in = '0;
               case (req.payload.command)
                  CMD_TICK: begin
                     tc_in = tc_ff + 64'd1;
                     state_in = S_SCAN;
                  end
                  CMD_WAKE: state_in = S_SCAN;
                  CMD_YIELD: begin
                     idx_in = (SW+1)'(1);
                     state_in = S_YSCAN;
                  end
                  CMD_SLEEP: begin
                     if (cur_ff == '0) begin
                        out_in.status = STS_REFUSED;
                        state_in = S_DONE;
                     end else if (req.payload.sleep_ms == 32'd0) begin
                        state_in = S_DONE;
                     end else begin
                        dcnt_in = '0;
                        rem_in = '0;
                        quo_in = '0;
                        state_in = S_DIV;
                     end
                  end
                  CMD_BLOCK: begin
                     if (cur_ff == '0) begin
                        out_in.status = STS_REFUSED;
                        state_in = S_DONE;
                     end else begin
                        wr_in[cur_ff] = WR_INPUT;
                        sst_in[cur_ff] = ST_WAIT;
                        idx_in = (SW+1)'(1);
                        state_in = S_YSCAN;
                     end
                  end
                  CMD_ADMIT, CMD_RETIRE: begin
                     if (req.payload.slot == 4'd0 || 32'(req.payload.slot) >= SLOTS) begin
                        out_in.status = STS_BAD_SLOT;
                     end else if ((req.payload.command == CMD_ADMIT) !=
                                  (sst_ff[tslot] == ST_UNUSED)) begin
                        out_in.status = STS_BAD_SLOT;
                     end else begin
                        sst_in[tslot] =
                           (req.payload.command == CMD_ADMIT) ? ST_RUN : ST_UNUSED;
                        wr_in[tslot] = WR_NONE;
                        dl_in[tslot] = '0;
                        sl_in[tslot] = slice_ff;
                        rt_in[tslot] = '0;
                        sc_in[tslot] = '0;
                        if (req.payload.command == CMD_RETIRE && tslot == cur_ff) begin
                           cur_in = '0;
                           rf_in = 1'b1;
                        end
                     end
                     state_in = S_DONE;
                  end
                  default: state_in = S_DONE;
               endcase
            end
         end
         S_DIV: begin
            if ({1'b0, rsh[15:0]} >= {1'b0, divisor} || rsh[16]) begin
               rem_in = rsh - {1'b0, divisor};
               quo_in = {quo_ff[30:0], 1'b1};
            end else begin
               rem_in = rsh;
               quo_in = {quo_ff[30:0], 1'b0};
            end
            dcnt_in = dcnt_ff + 6'd1;
            if (dcnt_ff == 6'd31) begin
               wr_in[cur_ff] = WR_SLEEP;
               sst_in[cur_ff] = ST_WAIT;
               dl_in[cur_ff] = tc_ff + 64'(quo_in) +
                  ((rem_in != 17'd0 || quo_in == 32'd0) ? 64'd1 : 64'd0);
               idx_in = (SW+1)'(1);
               state_in = S_YSCAN;
            end
         end
         S_SCAN: begin
            if (sst_ff[idx_ff[SW-1:0]] == ST_WAIT) begin
               if (cmd_ff.command == CMD_TICK) begin
                  if (wr_ff[idx_ff[SW-1:0]] == WR_SLEEP && tc_ff >= dl_ff[idx_ff[SW-1:0]]) begin
                     sst_in[idx_ff[SW-1:0]] = ST_RUN;
                     wr_in[idx_ff[SW-1:0]] = WR_NONE;
                     dl_in[idx_ff[SW-1:0]] = '0;
                     rf_in = 1'b1;
                     out_in.woken_count = out_ff.woken_count + 5'd1;
                  end
               end else if (wr_ff[idx_ff[SW-1:0]] == WR_INPUT) begin
                  sst_in[idx_ff[SW-1:0]] = ST_RUN;
                  wr_in[idx_ff[SW-1:0]] = WR_NONE;
                  out_in.woken_count = out_ff.woken_count + 5'd1;
               end
            end
            idx_in = idx_ff + (SW+1)'(1);
            if (idx_ff == (SW+1)'(SLOTS-1)) begin
               state_in = (cmd_ff.command == CMD_TICK) ? S_CHARGE : S_DONE;
            end
         end
         S_CHARGE: begin
            if (cur_ff != '0 && sst_ff[cur_ff] == ST_RUN) begin
               rt_in[cur_ff] = rt_ff[cur_ff] + 32'd1;
               if (sl_ff[cur_ff] != 16'd0) begin
                  sl_in[cur_ff] = sl_ff[cur_ff] - 16'd1;
               end
               if (sl_ff[cur_ff] <= 16'd1) begin
                  rf_in = 1'b1;
               end
            end
            state_in = S_DONE;
         end
         S_YSCAN: begin
            if (ys != '0 && sst_ff[ys] == ST_RUN) begin
               if (ys == cur_ff) begin
                  if (sl_ff[ys] == 16'd0) begin
                     sl_in[ys] = slice_ff;
                  end
               end else begin
                  sl_in[ys] = slice_ff;
                  sc_in[ys] = sc_ff[ys] + 32'd1;
                  cur_in = ys;
                  out_in.switched = 1'b1;
               end
               rf_in = 1'b0;
               state_in = S_DONE;
            end else if (idx_ff == (SW+1)'(SLOTS)) begin
               out_in.none_runnable = 1'b1;
               out_in.switched = (cur_ff != '0);
               cur_in = '0;
               state_in = S_DONE;
            end else begin
               idx_in = idx_ff + (SW+1)'(1);
            end
         end
         S_DONE: begin
            out_in.running_slot = 4'(cur_ff);
            out_in.resched_pending = rf_ff;
            ov_in = 1'b1;
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      cmd_ff <= cmd_in;
      out_ff <= out_in;
      idx_ff <= idx_in;
      dcnt_ff <= dcnt_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      if (reset) begin
         state_ff <= S_IDLE;
         slice_ff <= SLICE_RESET;
         tms_ff <= TICK_MS_RESET;
         tc_ff <= '0;
         cur_ff <= '0;
         rf_ff <= 1'b0;
         ov_ff <= 1'b0;
         for (int i = 0; i < SLOTS; i++) begin
            sst_ff[i] <= ST_UNUSED;
            wr_ff[i] <= WR_NONE;
            dl_ff[i] <= '0;
            sl_ff[i] <= '0;
            rt_ff[i] <= '0;
            sc_ff[i] <= '0;
         end
      end else begin
         state_ff <= state_in;
         slice_ff <= slice_in;
         tms_ff <= tms_in;
         tc_ff <= tc_in;
         cur_ff <= cur_in;
         rf_ff <= rf_in;
         ov_ff <= ov_in;
         sst_ff <= sst_in;
         wr_ff <= wr_in;
         dl_ff <= dl_in;
         sl_ff <= sl_in;
         rt_ff <= rt_in;
         sc_ff <= sc_in;
      end
   end

`ifndef SYNTH
   a_idle_not_waiting: assert property (@(posedge clock) disable iff (reset)
      sst_ff[0] == ST_UNUSED) else $error("idle slot changed state");
   a_busy_not_ready: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_IDLE) |-> !req.ready) else $error("ready while busy");
   a_done_valid: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DONE) |=> ov_ff) else $error("result lost");
   a_switch_cur: assert property (@(posedge clock) disable iff (reset)
      (ov_ff && out_ff.switched && !out_ff.none_runnable) |-> out_ff.running_slot != 4'd0)
      else $error("switched to idle without none_runnable");
`endif
endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps
// Testbench for round_robin_task_scheduler: directed table, then random command streams.
// Depends on rrts_pkg, rrts_if and the scheduler RTL; predicts every response itself.
module tb_top;
   import rrts_pkg::*;

   localparam int NSLOT = 16;
   localparam int WATCHDOG_LIMIT = 20000;
   localparam int MAX_LOGGED = 10;

   logic clock;
   logic reset;
   logic csr_psel, csr_penable, csr_pwrite, csr_pready;
   logic [2:0] csr_paddr;
   logic [31:0] csr_pwdata, csr_prdata;

   rrts_if #(.payload_type(req_type)) req_ch (clock);
   rrts_if #(.payload_type(rsp_type)) rsp_ch (clock);

   round_robin_task_scheduler uut (
      .clock(clock), .reset(reset), .req(req_ch.sink), .rsp(rsp_ch.source),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   // Scheduler mirror.
   logic [15:0] m_slice, m_tick_ms;
   logic [1:0] m_state [NSLOT];
   logic [1:0] m_reason [NSLOT];
   logic [63:0] m_deadline [NSLOT];
   logic [15:0] m_slice_left [NSLOT];
   logic [31:0] m_run_ticks [NSLOT];
   logic [31:0] m_sched_count [NSLOT];
   logic [63:0] m_ticks;
   logic [3:0] m_current;
   logic m_resched;

   rsp_type expected_rsp_q[$];
   int mismatches;
   int sent_count, got_count;
   int idle_in_pct, stall_out_pct;
   int quiet_cycles;
   bit sched_running;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic void mirror_reset();
      m_slice = SLICE_RESET;
      m_tick_ms = TICK_MS_RESET;
      for (int s = 0; s < NSLOT; s++) begin
         m_state[s] = ST_UNUSED;
         m_reason[s] = WR_NONE;
         m_deadline[s] = '0;
         m_slice_left[s] = '0;
         m_run_ticks[s] = '0;
         m_sched_count[s] = '0;
      end
      m_ticks = '0;
      m_current = '0;
      m_resched = 1'b0;
   endfunction

   function automatic void clear_entry(int s);
      m_state[s] = ST_UNUSED;
      m_reason[s] = WR_NONE;
      m_deadline[s] = '0;
      m_slice_left[s] = m_slice;
      m_run_ticks[s] = '0;
      m_sched_count[s] = '0;
   endfunction

   function automatic void pick_next(inout rsp_type r);
      int cur, s;
      cur = m_current;
      for (int i = 1; i <= NSLOT; i++) begin
         s = (cur + i) % NSLOT;
         if (s != 0 && m_state[s] == ST_RUN) begin
            if (s == cur) begin
               if (m_slice_left[s] == 0) m_slice_left[s] = m_slice;
            end else begin
               m_slice_left[s] = m_slice;
               m_sched_count[s]++;
               m_current = s[3:0];
               r.switched = 1'b1;
            end
            m_resched = 1'b0;
            return;
         end
      end
      r.none_runnable = 1'b1;
      if (cur != 0) r.switched = 1'b1;
      m_current = '0;
   endfunction

   function automatic rsp_type schedule_step(req_type q);
      rsp_type r;
      int cur;
      logic [63:0] div, nticks;
      r = '0;
      cur = m_current;
      case (q.command)
         CMD_TICK: begin
            m_ticks++;
            for (int s = 0; s < NSLOT; s++) begin
               if (m_state[s] == ST_WAIT && m_reason[s] == WR_SLEEP &&
                     m_ticks >= m_deadline[s]) begin
                  m_state[s] = ST_RUN;
                  m_reason[s] = WR_NONE;
                  m_deadline[s] = '0;
                  m_resched = 1'b1;
                  r.woken_count++;
               end
            end
            if (cur != 0 && m_state[cur] == ST_RUN) begin
               m_run_ticks[cur]++;
               if (m_slice_left[cur] > 0) m_slice_left[cur]--;
               if (m_slice_left[cur] == 0) m_resched = 1'b1;
            end
         end
         CMD_SLEEP: begin
            if (cur == 0) begin
               r.status = STS_REFUSED;
            end else if (q.sleep_ms != 0) begin
               div = (m_tick_ms != 0) ? 64'(m_tick_ms) : 64'd1;
               nticks = (64'(q.sleep_ms) + div - 1) / div;
               if (nticks == 0) nticks = 1;
               m_reason[cur] = WR_SLEEP;
               m_deadline[cur] = m_ticks + nticks;
               m_state[cur] = ST_WAIT;
               pick_next(r);
            end
         end
         CMD_BLOCK: begin
            if (cur == 0) begin
               r.status = STS_REFUSED;
            end else begin
               m_reason[cur] = WR_INPUT;
               m_state[cur] = ST_WAIT;
               pick_next(r);
            end
         end
         CMD_WAKE: begin
            for (int s = 0; s < NSLOT; s++) begin
               if (m_state[s] == ST_WAIT && m_reason[s] == WR_INPUT) begin
                  m_state[s] = ST_RUN;
                  m_reason[s] = WR_NONE;
                  r.woken_count++;
               end
            end
         end
         CMD_YIELD: pick_next(r);
         CMD_ADMIT: begin
            if (q.slot == 0 || m_state[q.slot] != ST_UNUSED) begin
               r.status = STS_BAD_SLOT;
            end else begin
               clear_entry(q.slot);
               m_state[q.slot] = ST_RUN;
            end
         end
         CMD_RETIRE: begin
            if (q.slot == 0 || m_state[q.slot] == ST_UNUSED) begin
               r.status = STS_BAD_SLOT;
            end else begin
               clear_entry(q.slot);
               if (q.slot == cur) begin
                  m_current = '0;
                  m_resched = 1'b1;
               end
            end
         end
         default: ;
      endcase
      r.running_slot = m_current;
      r.resched_pending = m_resched;
      return r;
   endfunction

   task automatic note_mismatch(string what, int unsigned want, int unsigned got);
      mismatches++;
      if (mismatches <= MAX_LOGGED)
         $display("%0t: mismatch on %s: expected %0d, got %0d", $realtime, what, want, got);
   endtask

   // Response checking and receiver stalls.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            got_count++;
            if (expected_rsp_q.size() == 0) begin
               note_mismatch("unexpected response", 0, 1);
            end else begin
               rsp_type e;
               rsp_type a;
               e = expected_rsp_q.pop_front();
               a = rsp_ch.payload;
               if (a.running_slot !== e.running_slot)
                  note_mismatch("running_slot", e.running_slot, a.running_slot);
               if (a.switched !== e.switched)
                  note_mismatch("switched", e.switched, a.switched);
               if (a.none_runnable !== e.none_runnable)
                  note_mismatch("none_runnable", e.none_runnable, a.none_runnable);
               if (a.resched_pending !== e.resched_pending)
                  note_mismatch("resched_pending", e.resched_pending, a.resched_pending);
               if (a.woken_count !== e.woken_count)
                  note_mismatch("woken_count", e.woken_count, a.woken_count);
               if (a.status !== e.status)
                  note_mismatch("status", e.status, a.status);
            end
         end
         rsp_ch.ready <= ($urandom_range(99) >= stall_out_pct);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (sched_running && quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("Watchdog expired: no transaction for %0d cycles.", WATCHDOG_LIMIT);
         $display("** round_robin_task_scheduler: FAILED **");
         $finish;
      end
   end

   task automatic csr_write(int index, logic [15:0] value);
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= 3'(4 * index);
      csr_pwdata <= 32'(value);
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      if (index == CSR_SLICE) m_slice = value;
      else m_tick_ms = value;
      @(posedge clock);
      if (csr_prdata !== 32'(value))
         note_mismatch("register readback", 32'(value), csr_prdata);
   endtask

   task automatic send_command(req_type q, bit typed, rsp_type want);
      rsp_type p;
      while ($urandom_range(99) < idle_in_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.payload <= q;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      p = schedule_step(q);
      if (typed && p !== want)
         note_mismatch("directed table row vs prediction", want, p);
      expected_rsp_q.push_back(p);
      sent_count++;
   endtask

   task automatic drain();
      req_ch.valid <= 1'b0;
      while (expected_rsp_q.size() != 0) @(posedge clock);
      repeat (60) @(posedge clock);
   endtask

   function automatic req_type make_cmd(logic [2:0] c, logic [3:0] s, logic [31:0] ms);
      req_type q;
      q.command = c;
      q.slot = s;
      q.sleep_ms = ms;
      return q;
   endfunction

   function automatic rsp_type make_rsp(logic [3:0] run, logic sw, logic nr, logic rp,
                                        logic [4:0] wk, logic [1:0] st);
      rsp_type r;
      r.running_slot = run;
      r.switched = sw;
      r.none_runnable = nr;
      r.resched_pending = rp;
      r.woken_count = wk;
      r.status = st;
      return r;
   endfunction

   function automatic req_type random_cmd();
      int pick;
      logic [31:0] ms;
      pick = $urandom_range(99);
      case ($urandom_range(3))
         0: ms = 32'($urandom_range(40));
         1: ms = $urandom;
         2: ms = 32'hFFFF_FFFF - 32'($urandom_range(3));
         default: ms = 32'($urandom_range(300));
      endcase
      if (pick < 30) return make_cmd(CMD_TICK, 4'($urandom), $urandom);
      if (pick < 42) return make_cmd(CMD_SLEEP, 4'($urandom), ms);
      if (pick < 50) return make_cmd(CMD_BLOCK, 4'($urandom), $urandom);
      if (pick < 58) return make_cmd(CMD_WAKE, 4'($urandom), $urandom);
      if (pick < 75) return make_cmd(CMD_YIELD, 4'($urandom), $urandom);
      if (pick < 88) return make_cmd(CMD_ADMIT, 4'($urandom), $urandom);
      if (pick < 97) return make_cmd(CMD_RETIRE, 4'($urandom), $urandom);
      return make_cmd(CMD_UNUSED, 4'($urandom), $urandom);
   endfunction

   typedef struct {
      req_type cmd;
      bit typed;
      rsp_type want;
   } table_row_type;

   initial begin
      table_row_type rows[$];
      int slice_set [4] = '{1, 65535, 3, 10};
      int ms_set [4] = '{65535, 1, 7, 1000};
      mirror_reset();
      mismatches = 0;
      sent_count = 0;
      got_count = 0;
      idle_in_pct = 0;
      stall_out_pct = 0;
      sched_running = 1'b0;
      reset = 1'b1;
      req_ch.valid = 1'b0;
      req_ch.payload = '0;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      sched_running = 1'b1;

      // Directed part.
      rows.push_back('{make_cmd(CMD_YIELD, 0, 0), 1, make_rsp(0, 0, 1, 0, 0, STS_OK)});
      rows.push_back('{make_cmd(CMD_SLEEP, 0, 5), 1, make_rsp(0, 0, 0, 0, 0, STS_REFUSED)});
      rows.push_back('{make_cmd(CMD_BLOCK, 0, 0), 1, make_rsp(0, 0, 0, 0, 0, STS_REFUSED)});
      rows.push_back('{make_cmd(CMD_ADMIT, 0, 0), 1, make_rsp(0, 0, 0, 0, 0, STS_BAD_SLOT)});
      rows.push_back('{make_cmd(CMD_RETIRE, 15, 0), 1, make_rsp(0, 0, 0, 0, 0, STS_BAD_SLOT)});
      rows.push_back('{make_cmd(CMD_ADMIT, 15, 0), 1, make_rsp(0, 0, 0, 0, 0, STS_OK)});
      rows.push_back('{make_cmd(CMD_ADMIT, 15, 0), 1, make_rsp(0, 0, 0, 0, 0, STS_BAD_SLOT)});
      rows.push_back('{make_cmd(CMD_ADMIT, 1, 0), 1, make_rsp(0, 0, 0, 0, 0, STS_OK)});
      rows.push_back('{make_cmd(CMD_YIELD, 0, 0), 1, make_rsp(1, 1, 0, 0, 0, STS_OK)});
      rows.push_back('{make_cmd(CMD_YIELD, 0, 0), 1, make_rsp(15, 1, 0, 0, 0, STS_OK)});
      rows.push_back('{make_cmd(CMD_SLEEP, 0, 0), 1, make_rsp(15, 0, 0, 0, 0, STS_OK)});
      rows.push_back('{make_cmd(CMD_TICK, 0, 0), 0, '0});
      rows.push_back('{make_cmd(CMD_SLEEP, 0, 32'hFFFF_FFFF), 0, '0});
      rows.push_back('{make_cmd(CMD_BLOCK, 0, 0), 0, '0});
      rows.push_back('{make_cmd(CMD_WAKE, 0, 0), 0, '0});
      rows.push_back('{make_cmd(CMD_YIELD, 0, 0), 0, '0});
      rows.push_back('{make_cmd(CMD_SLEEP, 0, 2), 0, '0});
      rows.push_back('{make_cmd(CMD_TICK, 0, 0), 0, '0});
      rows.push_back('{make_cmd(CMD_TICK, 0, 0), 0, '0});
      rows.push_back('{make_cmd(CMD_RETIRE, 0, 0), 0, '0});
      rows.push_back('{make_cmd(CMD_UNUSED, 4'hF, 32'hFFFF_FFFF), 0, '0});
      rows.push_back('{make_cmd(CMD_RETIRE, 1, 0), 0, '0});
      rows.push_back('{make_cmd(CMD_RETIRE, 15, 0), 0, '0});
      foreach (rows[i]) begin
         send_command(rows[i].cmd, rows[i].typed, rows[i].want);
      end
      drain();

      // Random part over several register settings and idling phases.
      for (int phase = 0; phase < 4; phase++) begin
         csr_write(CSR_SLICE, 16'(slice_set[phase]));
         csr_write(CSR_TICK_MS, 16'(ms_set[phase]));
         case (phase)
            0: begin idle_in_pct = 0; stall_out_pct = 0; end
            1: begin idle_in_pct = 71; stall_out_pct = 0; end
            2: begin idle_in_pct = 0; stall_out_pct = 71; end
            default: begin idle_in_pct = 35; stall_out_pct = 35; end
         endcase
         for (int n = 0; n < 170; n++) begin
            send_command(random_cmd(), 1'b0, '0);
         end
         drain();
      end

      $display("Sent %0d commands, checked %0d responses over four register settings",
               sent_count, got_count);
      $display("and four idling phases; %0d mismatches.", mismatches);
      if (mismatches == 0 && expected_rsp_q.size() == 0)
         $display("** round_robin_task_scheduler: PASSED **");
      else
         $display("** round_robin_task_scheduler: FAILED **");
      $finish;
   end
endmodule
